/* hdl/kll_pkg.sv */
package kll_pkg;

   // Result queue sizing: one request can raise at most two results.
   localparam int MAX_RESULTS = 2;
   localparam int FIFO_DEPTH  = 4;
   localparam int PTR_BITS    = 2;
   localparam int CNT_BITS    = 3;

   // Token kinds.
   localparam logic [5:0] K_EOF       = 6'd0;
   localparam logic [5:0] K_VECTOR    = 6'd16;
   localparam logic [5:0] K_IDENT     = 6'd19;
   localparam logic [5:0] K_FLOAT     = 6'd20;
   localparam logic [5:0] K_INT       = 6'd21;
   localparam logic [5:0] K_LPAREN    = 6'd22;
   localparam logic [5:0] K_RPAREN    = 6'd23;
   localparam logic [5:0] K_LBRACE    = 6'd24;
   localparam logic [5:0] K_RBRACE    = 6'd25;
   localparam logic [5:0] K_LBRACKET  = 6'd26;
   localparam logic [5:0] K_RBRACKET  = 6'd27;
   localparam logic [5:0] K_COMMA     = 6'd28;
   localparam logic [5:0] K_DOT       = 6'd29;
   localparam logic [5:0] K_SEMI      = 6'd30;
   localparam logic [5:0] K_MINUS     = 6'd31;
   localparam logic [5:0] K_PLUS      = 6'd32;
   localparam logic [5:0] K_SLASH     = 6'd33;
   localparam logic [5:0] K_STAR      = 6'd34;
   localparam logic [5:0] K_PERCENT   = 6'd35;
   localparam logic [5:0] K_NE        = 6'd36;
   localparam logic [5:0] K_NOT       = 6'd37;
   localparam logic [5:0] K_EQEQ      = 6'd38;
   localparam logic [5:0] K_ASSIGN    = 6'd39;
   localparam logic [5:0] K_GE        = 6'd40;
   localparam logic [5:0] K_SHR       = 6'd41;
   localparam logic [5:0] K_VEC_CLOSE = 6'd42;
   localparam logic [5:0] K_GT        = 6'd43;
   localparam logic [5:0] K_LE        = 6'd44;
   localparam logic [5:0] K_SHL       = 6'd45;
   localparam logic [5:0] K_VEC_OPEN  = 6'd46;
   localparam logic [5:0] K_LT        = 6'd47;
   localparam logic [5:0] K_INVALID   = 6'd48;

   localparam logic [7:0] CH_DOT  = ".";
   localparam logic [7:0] CH_EQ   = "=";
   localparam logic [7:0] CH_GT   = ">";
   localparam logic [7:0] CH_LT   = "<";
   localparam logic [7:0] CH_BANG = "!";

   localparam int KW_COUNT = 18;

   // Keyword text, first character in the top byte, padded with zeros.
   localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
      {"and", 24'h0}, {"or", 32'h0}, {"if", 32'h0}, {"else", 16'h0},
      {"elif", 16'h0}, {"for", 24'h0}, {"while", 8'h0}, {"print", 8'h0},
      "return", {"true", 16'h0}, {"false", 8'h0}, {"nil", 24'h0},
      "string", {"int", 24'h0}, {"float", 8'h0}, "vector",
      {"out", 24'h0}, {"inp", 24'h0}
   };

   localparam logic [2:0] KW_LEN [KW_COUNT] = '{
      3'd3, 3'd2, 3'd2, 3'd4, 3'd4, 3'd3, 3'd5, 3'd5, 3'd6,
      3'd4, 3'd5, 3'd3, 3'd6, 3'd3, 3'd5, 3'd6, 3'd3, 3'd3
   };

   typedef struct packed {
      logic [5:0]  kind;
      logic [7:0]  length;
      logic [31:0] end_offset;
      logic        last;
   } token_type;

   typedef struct packed {
      logic [1:0] count;
      token_type  tok0;
      token_type  tok1;
   } push_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_op_start(input logic [7:0] c);
      return c == CH_BANG || c == CH_EQ || c == CH_LT || c == CH_GT;
   endfunction

   function automatic logic [5:0] punct_kind(input logic [7:0] c);
      logic [5:0] k;
      unique case (c)
         "(":     k = K_LPAREN;
         ")":     k = K_RPAREN;
         "{":     k = K_LBRACE;
         "}":     k = K_RBRACE;
         "[":     k = K_LBRACKET;
         "]":     k = K_RBRACKET;
         ",":     k = K_COMMA;
         ".":     k = K_DOT;
         ";":     k = K_SEMI;
         "-":     k = K_MINUS;
         "+":     k = K_PLUS;
         "/":     k = K_SLASH;
         "*":     k = K_STAR;
         "%":     k = K_PERCENT;
         default: k = K_INVALID;
      endcase
      return k;
   endfunction

   // Words longer than six characters never match, as no keyword is longer than six.
   function automatic logic [5:0] word_kind(input logic [47:0] prefix,
                                            input logic [7:0]  count);
      logic [5:0]  k;
      logic [47:0] mask;
      k = K_IDENT;
      for (int i = 0; i < KW_COUNT; i++) begin
         mask = ~(48'hFFFF_FFFF_FFFF >> (6'(KW_LEN[i]) * 6'd8));
         if (count == 8'(KW_LEN[i]) && ((prefix ^ KW_TEXT[i]) & mask) == 48'h0) begin
            k = 6'(i + 1);
         end
      end
      return k;
   endfunction

endpackage

/* hdl/kll_core.sv */
module kll_core #(
   parameter int LEN_CAP     = 255,
   parameter int OFFSET_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  logic [7:0]        item_char,
   input  logic              item_end,
   output kll_pkg::push_type push
);

   typedef enum logic [4:0] {
      MODE_IDLE = 5'b00001,
      MODE_WORD = 5'b00010,
      MODE_INT  = 5'b00100,
      MODE_FRAC = 5'b01000,
      MODE_OP   = 5'b10000
   } mode_type;

   typedef enum logic [1:0] {
      OP_BANG = 2'd0,
      OP_EQ   = 2'd1,
      OP_GT   = 2'd2,
      OP_LT   = 2'd3
   } op_type;

   mode_type               mode_ff, mode_in;
   logic [47:0]            prefix_ff, prefix_in;
   logic [7:0]             count_ff, count_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic                   vflag_ff, vflag_in;
   op_type                 op_ff, op_in;

   logic                   fl_valid;
   logic [5:0]             fl_kind;
   logic [7:0]             fl_len;
   logic                   fl_vflag;
   logic [7:0]             count_sat;
   logic [7:0]             len_rep;
   logic [OFFSET_BITS-1:0] offset_next;

   assign count_sat   = (count_ff == 8'hFF) ? count_ff : count_ff + 8'd1;
   assign len_rep     = (count_ff > 8'(LEN_CAP)) ? 8'(LEN_CAP) : count_ff;
   assign offset_next = offset_ff + 1'b1;

   // The token under way, as it would be emitted if the current byte ends it.
   always_comb begin
      fl_valid = 1'b1;
      fl_kind  = kll_pkg::K_INVALID;
      fl_len   = len_rep;
      fl_vflag = vflag_ff;
      unique case (mode_ff)
         MODE_WORD: begin
            fl_kind = kll_pkg::word_kind(prefix_ff, count_ff);
            if (fl_kind == kll_pkg::K_VECTOR) begin
               fl_vflag = 1'b1;
            end
         end
         MODE_INT:  fl_kind = kll_pkg::K_INT;
         MODE_FRAC: fl_kind = kll_pkg::K_FLOAT;
         MODE_OP: begin
            fl_len = 8'd1;
            unique case (op_ff)
               OP_BANG: fl_kind = kll_pkg::K_NOT;
               OP_EQ:   fl_kind = kll_pkg::K_ASSIGN;
               OP_GT: begin
                  fl_kind  = vflag_ff ? kll_pkg::K_VEC_CLOSE : kll_pkg::K_GT;
                  fl_vflag = 1'b0;
               end
               OP_LT:   fl_kind = vflag_ff ? kll_pkg::K_VEC_OPEN : kll_pkg::K_LT;
               default: fl_kind = kll_pkg::K_LT;
            endcase
         end
         default: fl_valid = 1'b0;
      endcase
   end

   always_comb begin
      logic              fa;
      logic              fb;
      logic              do_flush;
      logic              start_idle;
      kll_pkg::token_type tok_a;
      kll_pkg::token_type tok_b;
      logic [7:0]        c;

      c          = item_char;
      fa         = 1'b0;
      fb         = 1'b0;
      do_flush   = 1'b0;
      start_idle = 1'b0;
      mode_in    = mode_ff;
      prefix_in  = prefix_ff;
      count_in   = count_ff;
      offset_in  = offset_ff;
      vflag_in   = vflag_ff;
      op_in      = op_ff;

      tok_a.kind       = fl_kind;
      tok_a.length     = fl_len;
      tok_a.end_offset = 32'(offset_ff);
      tok_a.last       = 1'b0;
      tok_b.kind       = kll_pkg::K_EOF;
      tok_b.length     = 8'd0;
      tok_b.end_offset = 32'(offset_next);
      tok_b.last       = 1'b1;

      if (item_valid) begin
         if (item_end) begin
            // Flush what is pending, then EOF at the same offset, then start afresh.
            fa               = fl_valid;
            fb               = 1'b1;
            tok_b.end_offset = 32'(offset_ff);
            mode_in          = MODE_IDLE;
            prefix_in        = 48'h0;
            count_in         = 8'd0;
            offset_in        = '0;
            vflag_in         = 1'b0;
            op_in            = OP_BANG;
         end else begin
            offset_in = offset_next;
            unique case (mode_ff)
               MODE_WORD: begin
                  if (kll_pkg::is_alpha(c) || kll_pkg::is_digit(c)) begin
                     if (count_ff < 8'd6) begin
                        prefix_in[6'(6'd47 - {count_ff[2:0], 3'b000}) -: 8] = c;
                     end
                     count_in = count_sat;
                  end else begin
                     do_flush = 1'b1;
                  end
               end
               MODE_INT: begin
                  if (kll_pkg::is_digit(c)) begin
                     count_in = count_sat;
                  end else if (c == kll_pkg::CH_DOT) begin
                     count_in = count_sat;
                     mode_in  = MODE_FRAC;
                  end else begin
                     do_flush = 1'b1;
                  end
               end
               MODE_FRAC: begin
                  if (kll_pkg::is_digit(c)) begin
                     count_in = count_sat;
                  end else begin
                     do_flush = 1'b1;
                  end
               end
               MODE_OP: begin
                  if (c == kll_pkg::CH_EQ) begin
                     fb           = 1'b1;
                     tok_b.length = 8'd2;
                     mode_in      = MODE_IDLE;
                     unique case (op_ff)
                        OP_BANG: tok_b.kind = kll_pkg::K_NE;
                        OP_EQ:   tok_b.kind = kll_pkg::K_EQEQ;
                        OP_GT:   tok_b.kind = kll_pkg::K_GE;
                        default: tok_b.kind = kll_pkg::K_LE;
                     endcase
                  end else if (op_ff == OP_GT && c == kll_pkg::CH_GT) begin
                     fb           = 1'b1;
                     tok_b.kind   = kll_pkg::K_SHR;
                     tok_b.length = 8'd2;
                     mode_in      = MODE_IDLE;
                  end else if (op_ff == OP_LT && c == kll_pkg::CH_LT) begin
                     fb           = 1'b1;
                     tok_b.kind   = kll_pkg::K_SHL;
                     tok_b.length = 8'd2;
                     mode_in      = MODE_IDLE;
                  end else begin
                     do_flush = 1'b1;
                  end
               end
               default: start_idle = 1'b1;
            endcase

            if (do_flush) begin
               fa         = 1'b1;
               vflag_in   = fl_vflag;
               start_idle = 1'b1;
            end

            if (start_idle) begin
               mode_in = MODE_IDLE;
               if (kll_pkg::is_space(c)) begin
                  mode_in = MODE_IDLE;
               end else if (kll_pkg::is_alpha(c)) begin
                  prefix_in = {c, 40'h0};
                  count_in  = 8'd1;
                  mode_in   = MODE_WORD;
               end else if (kll_pkg::is_digit(c)) begin
                  count_in = 8'd1;
                  mode_in  = MODE_INT;
               end else if (kll_pkg::is_op_start(c)) begin
                  count_in = 8'd1;
                  mode_in  = MODE_OP;
                  if (c == kll_pkg::CH_BANG) begin
                     op_in = OP_BANG;
                  end else if (c == kll_pkg::CH_EQ) begin
                     op_in = OP_EQ;
                  end else if (c == kll_pkg::CH_GT) begin
                     op_in = OP_GT;
                  end else begin
                     op_in = OP_LT;
                  end
               end else begin
                  fb           = 1'b1;
                  tok_b.kind   = kll_pkg::punct_kind(c);
                  tok_b.length = 8'd1;
               end
            end
         end
      end

      tok_a.last = ~fb;
      push.count = {1'b0, fa} + {1'b0, fb};
      push.tok0  = fa ? tok_a : tok_b;
      push.tok1  = tok_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         prefix_ff <= 48'h0;
         count_ff  <= 8'd0;
         offset_ff <= '0;
         vflag_ff  <= 1'b0;
         op_ff     <= OP_BANG;
      end else begin
         mode_ff   <= mode_in;
         prefix_ff <= prefix_in;
         count_ff  <= count_in;
         offset_ff <= offset_in;
         vflag_ff  <= vflag_in;
         op_ff     <= op_in;
      end
   end

   // An end request always reports EOF as its final result.
   assert property (@(posedge clock) disable iff (reset)
      (item_valid && item_end) |-> (push.count != 2'd0 &&
         ((push.count == 2'd1) ? push.tok0.kind : push.tok1.kind) == kll_pkg::K_EOF))
      else $error("end request without EOF");

   // Two results arise only when a pending token is flushed.
   assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (mode_ff != MODE_IDLE && !push.tok0.last))
      else $error("two results without a pending token");

   // After an end request the offset restarts at zero.
   assert property (@(posedge clock) disable iff (reset)
      (item_valid && item_end) |=> (offset_ff == '0 && mode_ff == MODE_IDLE))
      else $error("state not cleared after end request");

endmodule

/* hdl/kll_fifo.sv */
module kll_fifo (
   input  logic                             clock,
   input  logic                             reset,
   input  kll_pkg::push_type                push,
   input  logic                             pop,
   output kll_pkg::token_type               head,
   output logic [kll_pkg::CNT_BITS-1:0]     count
);

   kll_pkg::token_type                mem_ff [kll_pkg::FIFO_DEPTH];
   logic [kll_pkg::PTR_BITS-1:0]      wr_ff, wr_in;
   logic [kll_pkg::PTR_BITS-1:0]      rd_ff, rd_in;
   logic [kll_pkg::CNT_BITS-1:0]      count_ff, count_in;
   logic [kll_pkg::PTR_BITS-1:0]      wr_next;

   assign wr_next  = kll_pkg::PTR_BITS'(wr_ff + 1'b1);
   assign wr_in    = kll_pkg::PTR_BITS'(wr_ff + push.count);
   assign rd_in    = kll_pkg::PTR_BITS'(rd_ff + pop);
   assign count_in = kll_pkg::CNT_BITS'(count_ff + kll_pkg::CNT_BITS'(push.count)
                                        - kll_pkg::CNT_BITS'(pop));
   assign head     = mem_ff[rd_ff];
   assign count    = count_ff;

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ff] <= push.tok0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.tok1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= kll_pkg::CNT_BITS'(kll_pkg::FIFO_DEPTH))
      else $error("result queue count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      (4'(count_ff) + 4'(push.count)) <= 4'(kll_pkg::FIFO_DEPTH) + 4'(pop))
      else $error("result queue overflow");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("result queue underflow");

endmodule

/* hdl/keyword_lexer_tokenizer.sv */
// Streaming tokenizer: one source byte per request on the req_ channel, tokens
// out on the rsp_ channel.
// A request carries the byte in req_tdata; req_tlast high marks the end of the
// source, and then the byte is ignored, any pending token is flushed and an
// EOF token follows, after which the block starts again at offset zero.
// Each result gives the kind in rsp_tuser, length and end offset in rsp_tdata,
// and rsp_tlast high on the final result raised by one request.
// A request is registered at the edge it is taken and lexed in the following
// cycle into a four-entry result queue, and its results are registered there
// before they reach rsp_. One request per cycle is taken for as long as the
// receiver drains one result per cycle; a request that raises two results
// leaves one more result in the queue, and the queue occupancy sets req_tready.
// When the receiver stalls, results wait in the queue and req_tready falls
// once the queue could no longer absorb two more results.
// Synchronous reset clears the lexer state and empties the queue.
module keyword_lexer_tokenizer #(
   parameter int MAX_LEXEME  = 255,
   parameter int OFFSET_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_in
   input  logic        req_tlast,   // end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] token_length, [39:8] end_offset
   output logic [5:0]  rsp_tuser,   // [5:0] token_kind
   output logic        rsp_tlast    // last_of_item
);

   localparam int LEN_CAP = (MAX_LEXEME < 255) ? MAX_LEXEME : 255;

   logic                          valid_ff, valid_in;
   logic [7:0]                    char_ff;
   logic                          end_ff;
   logic                          req_accept;
   logic                          rsp_accept;
   kll_pkg::push_type             push;
   kll_pkg::token_type            head;
   logic [kll_pkg::CNT_BITS-1:0]  count;

   // Room is counted against the results of the request now being lexed.
   assign req_tready = (count + kll_pkg::CNT_BITS'(push.count))
                       <= kll_pkg::CNT_BITS'(kll_pkg::FIFO_DEPTH - kll_pkg::MAX_RESULTS);
   assign req_accept = req_tvalid && req_tready;
   assign valid_in   = req_accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         char_ff <= req_tdata;
         end_ff  <= req_tlast;
      end
   end

   kll_core #(
      .LEN_CAP     (LEN_CAP),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (valid_ff),
      .item_char  (char_ff),
      .item_end   (end_ff),
      .push       (push)
   );

   assign rsp_tvalid = (count != '0);
   assign rsp_accept = rsp_tvalid && rsp_tready;

   kll_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (rsp_accept),
      .head  (head),
      .count (count)
   );

   assign rsp_tdata = {head.end_offset, head.length};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule
